### rtl/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared types, codes and sizes for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Default number of job slots in the table.
	localparam int SLOTS_DEF = 16;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Field widths.
	localparam int ID_W    = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 3;

	// Input word kinds as they arrive on the stream.
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_ARRIVE = 1'b1;

	// Classification made by the front before queueing.
	typedef enum logic [1:0] {
		OP_TICK        = 2'd0,
		OP_ARRIVE      = 2'd1,
		OP_ZERO_BURST  = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		RES_ACCEPTED   = 3'd0,
		RES_FULL       = 3'd1,
		RES_ZERO_BURST = 3'd2,
		RES_IDLE       = 3'd3,
		RES_RAN        = 3'd4,
		RES_FINISHED   = 3'd5
	} status_t;

	// One classified word held in the queue.
	typedef struct packed {
		op_t                op;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst_units;
		logic [PRIO_W-1:0]  job_priority;
	} item_t;

	// One row of the slot table.
	typedef struct packed {
		logic [ID_W-1:0]    job;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] left;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
	} row_t;

	// One result word.
	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   served_id;
		logic [TIME_W-1:0] now_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
	} result_t;

endpackage

### rtl/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Keeps a table of job slots and a saturating time counter. An arrival word
// places a job in the lowest free slot; a tick word runs the ready job with
// the lowest priority number (lowest slot on a tie) for one time unit.
//
//  Channel  Direction  Handshake            Contents
//  s_       in         s_tvalid / s_tready  tdata: job_id, burst_units,
//                                           job_priority; tuser: kind
//  m_       out        m_tvalid / m_tready  tdata: served_id, now_time,
//                                           turnaround, wait_time; tuser: status
//
// The back end walks over the slot table, which it reads one slot per cycle
// from the table memory. A zero-burst arrival skips the walk.
// Reset clears all slots and the time counter; no clearing pass is needed.
// A two-word queue lets the input side keep accepting while a word is being
// worked on, and the output register holds a result while the next word runs.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
	parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // job_id[15:0], burst_units[31:16], job_priority[39:32]
	input  logic [0:0]   s_tuser,  // kind[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // served_id[15:0], now_time[47:16],
	                               // turnaround[79:48], wait_time[111:80]
	output logic [2:0]   m_tuser   // status[2:0]
);
	import pps_pkg::*;

	logic    push;
	item_t   push_item;
	logic    q_full;
	logic    pop;
	logic    q_valid;
	item_t   q_item;
	result_t out_word;
	logic [31:0] clock_now;

	// Front end: accept and classify.
	pps_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Queue between the two halves.
	pps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// Back end: slot table and scheduling.
	pps_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word),
		.clock_now (clock_now)
	);

	// Output packing.
	assign m_tuser = out_word.status;
	assign m_tdata = {out_word.wait_time, out_word.turnaround,
		out_word.now_time, out_word.served_id};

	// The time counter never moves backwards.
	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> clock_now >= $past(clock_now))
		else $error("time counter decreased");

	// Only a finished word carries turnaround and waiting time.
	a_times_only_finished: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != RES_FINISHED) |-> m_tdata[111:48] == '0)
		else $error("turnaround or waiting time on a word that did not finish");

	// Waiting time never exceeds turnaround.
	a_wait_le_tat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RES_FINISHED) |-> m_tdata[111:80] <= m_tdata[79:48])
		else $error("waiting time above turnaround");

	// An idle tick names no job.
	a_idle_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RES_IDLE) |-> m_tdata[15:0] == '0)
		else $error("idle result carries a job identifier");

endmodule

### rtl/pps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input words and classifies them as tick, arrival or rejected
// arrival with a zero burst, then pushes them into the queue.
// ----------------------------------------------------------------------------
module pps_front (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,
	input  logic [0:0]            s_tuser,
	input  logic                  q_full,
	output logic                  push,
	output pps_pkg::item_t        push_item
);
	import pps_pkg::*;

	// Accept whenever the queue has room.
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Unpack the word and classify it.
	always_comb begin
		push_item.job_id       = s_tdata[15:0];
		push_item.burst_units  = s_tdata[31:16];
		push_item.job_priority = s_tdata[39:32];
		if (s_tuser[0] == KIND_TICK) begin
			push_item.op = OP_TICK;
		end else if (s_tdata[31:16] == '0) begin
			push_item.op = OP_ZERO_BURST;
		end else begin
			push_item.op = OP_ARRIVE;
		end
	end

endmodule

### rtl/pps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler decoupling queue
// Short first-in first-out queue of classified words between the front
// and the back.
// ----------------------------------------------------------------------------
module pps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pps_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output pps_pkg::item_t q_item
);
	import pps_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t           entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/pps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler back end
// Holds the slot table and the time counter, walks the table one slot per
// cycle to find a free slot or the best ready job, updates the chosen slot
// and presents one result word through an output register.
// ----------------------------------------------------------------------------
module pps_back #(
	parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  pps_pkg::item_t        q_item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pps_pkg::result_t      out_word,
	output logic [31:0]           clock_now
);
	import pps_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_FETCH  = 6'b001000,
		S_WAIT   = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	state_t              state_q;
	item_t               cur_q;
	logic [CW-1:0]       idx_q;
	logic                chk_valid_s1;
	logic [IW-1:0]       chk_idx_s1;
	logic                found_q;
	logic [IW-1:0]       best_q;
	logic [PRIO_W-1:0]   best_prio_q;
	logic [SLOTS-1:0]    valid_q;
	logic [TIME_W-1:0]   clock_q;
	row_t                mem [SLOTS];
	row_t                rdata_q;
	logic [TIME_W-1:0]   tat_q;
	logic [BURST_W-1:0]  burst_q;
	status_t             res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic [TIME_W-1:0]   res_tat_q;
	logic [TIME_W-1:0]   res_wait_q;
	logic                out_valid_q;
	result_t             out_q;

	logic                scan_end;
	logic [IW-1:0]       rd_addr;
	logic                mem_we;
	row_t                mem_wd;
	logic [BURST_W-1:0]  left_new;
	logic                take_slot;
	logic                load_out;

	assign scan_end  = (idx_q == CW'(SLOTS));
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign load_out  = (state_q == S_RESULT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign clock_now = clock_q;
	assign left_new  = rdata_q.left - BURST_W'(rdata_q.left != '0);

	// Read address: the scan index while walking, the chosen slot otherwise.
	always_comb begin
		if (state_q == S_SCAN && !scan_end) begin
			rd_addr = idx_q[IW-1:0];
		end else begin
			rd_addr = best_q;
		end
	end

	// Decide whether the slot under inspection replaces the current pick.
	always_comb begin
		take_slot = 1'b0;
		if (chk_valid_s1) begin
			if (cur_q.op == OP_ARRIVE) begin
				take_slot = !valid_q[chk_idx_s1] && !found_q;
			end else begin
				take_slot = valid_q[chk_idx_s1] &&
					(!found_q || rdata_q.prio < best_prio_q);
			end
		end
	end

	// Table write: a new row on acceptance, the decremented count on a run.
	always_comb begin
		mem_we = 1'b0;
		mem_wd = rdata_q;
		case (state_q)
			S_DECIDE: begin
				if (cur_q.op == OP_ARRIVE && found_q) begin
					mem_we         = 1'b1;
					mem_wd.job     = cur_q.job_id;
					mem_wd.prio    = cur_q.job_priority;
					mem_wd.left    = cur_q.burst_units;
					mem_wd.burst   = cur_q.burst_units;
					mem_wd.arrival = clock_q;
				end
			end
			S_FETCH: begin
				if (left_new != '0) begin
					mem_we      = 1'b1;
					mem_wd.left = left_new;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Slot table memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[best_q] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			chk_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			valid_q      <= '0;
			clock_q      <= '0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					chk_valid_s1 <= 1'b0;
					found_q      <= 1'b0;
					idx_q        <= '0;
					if (q_valid) begin
						state_q <= (q_item.op == OP_ZERO_BURST) ? S_RESULT : S_SCAN;
					end
				end
				S_SCAN: begin
					chk_valid_s1 <= !scan_end;
					if (!scan_end) begin
						idx_q <= idx_q + 1'b1;
					end
					if (take_slot) begin
						found_q <= 1'b1;
					end
					if (scan_end && !chk_valid_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (cur_q.op == OP_ARRIVE) begin
						if (found_q) begin
							valid_q[best_q] <= 1'b1;
						end
						state_q <= S_RESULT;
					end else begin
						if (clock_q != '1) begin
							clock_q <= clock_q + 1'b1;
						end
						state_q <= found_q ? S_FETCH : S_RESULT;
					end
				end
				S_FETCH: begin
					if (left_new == '0) begin
						valid_q[best_q] <= 1'b0;
						state_q         <= S_WAIT;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_WAIT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working payload and result fields.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status     <= res_status_q;
			out_q.served_id  <= res_id_q;
			out_q.now_time   <= clock_q;
			out_q.turnaround <= res_tat_q;
			out_q.wait_time  <= res_wait_q;
		end
		chk_idx_s1 <= idx_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				cur_q        <= q_item;
				res_id_q     <= q_item.job_id;
				res_status_q <= RES_ZERO_BURST;
				res_tat_q    <= '0;
				res_wait_q   <= '0;
			end
			S_SCAN: begin
				if (take_slot) begin
					best_q      <= chk_idx_s1;
					best_prio_q <= rdata_q.prio;
				end
			end
			S_DECIDE: begin
				if (cur_q.op == OP_ARRIVE) begin
					res_status_q <= found_q ? RES_ACCEPTED : RES_FULL;
				end else if (!found_q) begin
					res_status_q <= RES_IDLE;
					res_id_q     <= '0;
				end
			end
			S_FETCH: begin
				res_id_q     <= rdata_q.job;
				res_status_q <= RES_RAN;
				tat_q        <= clock_q - rdata_q.arrival;
				burst_q      <= rdata_q.burst;
			end
			S_WAIT: begin
				res_status_q <= RES_FINISHED;
				res_tat_q    <= tat_q;
				if (tat_q > TIME_W'(burst_q)) begin
					res_wait_q <= tat_q - TIME_W'(burst_q);
				end else begin
					res_wait_q <= '0;
				end
			end
			default: begin
				res_id_q <= res_id_q;
			end
		endcase
	end

endmodule

### dv/tb_preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Feeds arrival and tick words into the scheduler and checks every result
// against a scheduler model kept in the bench. The model holds its own slot
// table and time counter. A directed opening covers idle ticks, zero bursts,
// priority ties, preemption and a full table. A random body then mixes
// arrivals and ticks in phases of changing load. Both handshakes idle at
// random, and the receiver holds off once for a long stretch so that the
// block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;

	import pps_pkg::*;

	localparam int NUM_SLOTS = SLOTS_DEF;

	// One input word as the bench sees it.
	typedef struct {
		logic               kind;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} in_word_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // job_id[15:0], burst_units[31:16], job_priority[39:32]
	logic [0:0]   s_tuser;   // kind[0]
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;   // served_id[15:0], now_time[47:16],
	                         // turnaround[79:48], wait_time[111:80]
	logic [2:0]   m_tuser;   // status[2:0]

	// Scheduler model state.
	logic               slot_busy [NUM_SLOTS];
	logic [ID_W-1:0]    slot_id   [NUM_SLOTS];
	logic [PRIO_W-1:0]  slot_pri  [NUM_SLOTS];
	logic [BURST_W-1:0] slot_rem  [NUM_SLOTS];
	logic [BURST_W-1:0] slot_len  [NUM_SLOTS];
	logic [TIME_W-1:0]  slot_arr  [NUM_SLOTS];
	logic [TIME_W-1:0]  sched_clock;

	in_word_t word_queue[$];
	result_t  awaited_results[$];
	bit       word_taken;
	int       gap_left;
	int       stall_left;
	int       hold_left;
	bit       hold_done;
	int       results_seen;
	int       mismatch_count;

	preemptive_priority_scheduler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Works out the result of one word and updates the scheduler model.
	function automatic result_t schedule_word(in_word_t w);
		result_t            r;
		int                 pick;
		int                 free_idx;
		logic [TIME_W-1:0]  tat;
		r = '0;
		if (w.kind == KIND_ARRIVE) begin
			r.served_id = w.job_id;
			if (w.burst == '0) begin
				r.status = RES_ZERO_BURST;
			end else begin
				free_idx = -1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!slot_busy[i] && free_idx < 0) free_idx = i;
				end
				if (free_idx < 0) begin
					r.status = RES_FULL;
				end else begin
					slot_busy[free_idx] = 1'b1;
					slot_id[free_idx]   = w.job_id;
					slot_pri[free_idx]  = w.prio;
					slot_rem[free_idx]  = w.burst;
					slot_len[free_idx]  = w.burst;
					slot_arr[free_idx]  = sched_clock;
					r.status = RES_ACCEPTED;
				end
			end
		end else begin
			// Lowest priority number wins; the strict compare keeps the lowest slot on a tie.
			pick = -1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slot_busy[i] && (pick < 0 || slot_pri[i] < slot_pri[pick])) pick = i;
			end
			if (sched_clock != '1) sched_clock = sched_clock + 1;
			if (pick < 0) begin
				r.status = RES_IDLE;
			end else begin
				r.served_id = slot_id[pick];
				if (slot_rem[pick] != '0) slot_rem[pick] = slot_rem[pick] - 1;
				if (slot_rem[pick] == '0) begin
					slot_busy[pick] = 1'b0;
					tat = sched_clock - slot_arr[pick];
					r.turnaround = tat;
					r.wait_time  = (tat > slot_len[pick]) ? tat - slot_len[pick] : '0;
					r.status = RES_FINISHED;
				end else begin
					r.status = RES_RAN;
				end
			end
		end
		r.now_time = sched_clock;
		return r;
	endfunction

	task automatic add_word(logic kind, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
			logic [PRIO_W-1:0] prio);
		in_word_t w;
		w.kind   = kind;
		w.job_id = id;
		w.burst  = burst;
		w.prio   = prio;
		word_queue = {word_queue, w};
	endtask

	// Input side: one decision per falling edge, one assignment per signal.
	always @(negedge clk) begin
		logic     next_valid;
		in_word_t w;
		next_valid = s_tvalid && !word_taken;
		word_taken = 1'b0;
		if (!next_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (word_queue.size() > 0) begin
				w = word_queue.pop_front();
				next_valid = 1'b1;
				s_tdata <= {w.prio, w.burst, w.job_id};
				s_tuser <= w.kind;
				gap_left = pick_gap();
			end
		end
		s_tvalid <= next_valid;
	end

	// Output side: random stalls, plus one long hold-off once results are flowing.
	always @(negedge clk) begin
		logic rdy;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!hold_done && results_seen >= 120) begin
			hold_done = 1'b1;
			hold_left = 400;
			rdy = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
			if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
		end
		m_tready <= rdy;
	end

	// Accepted words feed the model; accepted results are checked in order.
	always @(posedge clk) begin
		in_word_t w;
		result_t  want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				w.kind   = s_tuser[0];
				w.job_id = s_tdata[15:0];
				w.burst  = s_tdata[31:16];
				w.prio   = s_tdata[39:32];
				want = schedule_word(w);
				awaited_results = {awaited_results, want};
				word_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result status %0d id %h", $realtime,
							m_tuser, m_tdata[15:0]);
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser !== want.status || m_tdata[15:0] !== want.served_id ||
							m_tdata[47:16] !== want.now_time ||
							m_tdata[79:48] !== want.turnaround ||
							m_tdata[111:80] !== want.wait_time) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("%0t: result mismatch, expected st %0d id %h now %0d tat %0d wait %0d, ",
								$realtime, want.status, want.served_id, want.now_time,
								want.turnaround, want.wait_time);
							$display("got st %0d id %h now %0d tat %0d wait %0d",
								m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[79:48],
								m_tdata[111:80]);
						end
					end
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int arrive_pct;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		word_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		results_seen = 0;
		mismatch_count = 0;
		sched_clock = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_busy[i] = 1'b0;
			slot_id[i]   = '0;
			slot_pri[i]  = '0;
			slot_rem[i]  = '0;
			slot_len[i]  = '0;
			slot_arr[i]  = '0;
		end

		// Tick on an empty table, then a zero-burst arrival with extreme fields.
		add_word(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
		add_word(KIND_ARRIVE, 16'hFFFF, 16'h0000, 8'h00);
		// A one-unit job finishes on the next tick.
		add_word(KIND_ARRIVE, 16'h0000, 16'h0001, 8'h00);
		add_word(KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
		// Equal priorities go to the lowest slot; a later urgent job preempts.
		add_word(KIND_ARRIVE, 16'h00A1, 16'h0002, 8'h07);
		add_word(KIND_ARRIVE, 16'h00B2, 16'h0001, 8'h07);
		add_word(KIND_ARRIVE, 16'h00C3, 16'h0003, 8'h09);
		add_word(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
		add_word(KIND_ARRIVE, 16'h00D4, 16'h0001, 8'h02);
		repeat (3) add_word(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
		// Fill the table, overflow it, and send a zero burst to the full table.
		repeat (NUM_SLOTS - 1)
			add_word(KIND_ARRIVE, 16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4)),
				8'($urandom_range(0, 255)));
		add_word(KIND_ARRIVE, 16'h5A5A, 16'h0005, 8'h01);
		add_word(KIND_ARRIVE, 16'hA5A5, 16'h0000, 8'hFF);

		// Random body in phases of light, medium and heavy arrival load.
		arrive_pct = 45;
		for (int n = 0; n < 400; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: arrive_pct = 20;
					1: arrive_pct = 45;
					default: arrive_pct = 70;
				endcase
			end
			if ($urandom_range(0, 99) < arrive_pct) begin
				burst = ($urandom_range(0, 99) < 8) ? '0 : 16'($urandom_range(1, 6));
				prio  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) :
					8'($urandom_range(0, 255));
				add_word(KIND_ARRIVE, 16'($urandom_range(0, 65535)), burst, prio);
			end else begin
				add_word(KIND_TICK, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end
		end

		// A longest-burst job at the back; it never drains, so it comes last.
		add_word(KIND_ARRIVE, 16'hFFFF, 16'hFFFF, 8'hFF);
		repeat (3) add_word(KIND_TICK, 16'h0000, 16'h0000, 8'h00);

		// Wait for every word to go in and every result to come back.
		do @(negedge clk);
		while (word_queue.size() != 0 || s_tvalid || awaited_results.size() != 0);
		repeat (NUM_SLOTS + 20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("preemptive_priority_scheduler test passed");
		end else begin
			$display("preemptive_priority_scheduler test failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("preemptive_priority_scheduler test failed");
		$finish;
	end

endmodule
